>>> hdl/msxf_pkg.sv
// ----------------------------------------------------------------------------
// msxf_pkg
// Shared types and constants of the monochrome sprite XOR frame store.
// ----------------------------------------------------------------------------
package msxf_pkg;

    localparam int SCREEN_WIDTH_DEF    = 64;
    localparam int SCREEN_HEIGHT_DEF   = 32;
    localparam int MAX_SPRITE_ROWS_DEF = 15;

    localparam int COORD_W = 8;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;

    localparam int S_DATA_W = 2 * COORD_W + BYTE_W;
    localparam int M_DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic draw;
        logic stop_rows;
    } t_row_ctl;

endpackage

>>> hdl/msxf_frame_mem.sv
// ----------------------------------------------------------------------------
// msxf_frame_mem
// Frame row memory with a registered read port and per-row valid bits, so
// that a clear darkens the whole frame at once.
// ----------------------------------------------------------------------------
module msxf_frame_mem
    import msxf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clear,
    input  logic                             i_rd_en,
    input  logic [$clog2(SCREEN_HEIGHT)-1:0] i_rd_addr,
    output logic [SCREEN_WIDTH-1:0]          o_rd_data,
    input  logic                             i_wr_en,
    input  logic [$clog2(SCREEN_HEIGHT)-1:0] i_wr_addr,
    input  logic [SCREEN_WIDTH-1:0]          i_wr_data
);

    logic [SCREEN_WIDTH-1:0]  r_mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_row_valid;
    logic [SCREEN_WIDTH-1:0]  r_rd_data;
    logic                     r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_live   <= 1'b0;
        end else begin
            if (i_clear) begin
                r_row_valid <= '0;
            end else if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_live <= r_row_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_live ? r_rd_data : '0;

endmodule

>>> hdl/msxf_pixel_map.sv
// ----------------------------------------------------------------------------
// msxf_pixel_map
// Maps an item's coordinates onto a frame row address, a pixel column and a
// row-wide XOR mask, applying wrapping or clipping at the edges.
// ----------------------------------------------------------------------------
module msxf_pixel_map
    import msxf_pkg::*;
#(
    parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = SCREEN_HEIGHT_DEF,
    parameter int MAX_SPRITE_ROWS = MAX_SPRITE_ROWS_DEF
) (
    input  logic                               i_is_draw,
    input  logic                               i_wrap,
    input  logic [COORD_W-1:0]                 i_x,
    input  logic [COORD_W-1:0]                 i_y,
    input  logic [BYTE_W-1:0]                  i_pattern,
    input  logic [$clog2(MAX_SPRITE_ROWS+1)-1:0] i_row_index,
    input  logic                               i_rows_stopped,
    output logic [$clog2(SCREEN_HEIGHT)-1:0]   o_row_addr,
    output logic [$clog2(SCREEN_WIDTH)-1:0]    o_col,
    output logic [SCREEN_WIDTH-1:0]            o_mask,
    output t_row_ctl                           o_ctl
);

    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int AW    = $clog2(SCREEN_HEIGHT);
    localparam int RIW   = $clog2(MAX_SPRITE_ROWS + 1);
    localparam int SUM_W = ((AW > RIW) ? AW : RIW) + 1;
    localparam int FULL_W = COORD_W + 1;
    localparam int NCODES = 1 << COORD_W;

    logic [XW-1:0] x_mod_tbl [NCODES];
    logic [AW-1:0] y_mod_tbl [NCODES];

    for (genvar g = 0; g < NCODES; g++) begin : g_mod_tbl
        assign x_mod_tbl[g] = XW'(g % SCREEN_WIDTH);
        assign y_mod_tbl[g] = AW'(g % SCREEN_HEIGHT);
    end

    logic [XW-1:0]     x_base;
    logic [AW-1:0]     y_base;
    logic [SUM_W-1:0]  y_sum;
    logic [SUM_W-1:0]  y_red1;
    logic [SUM_W-1:0]  y_red2;
    logic [FULL_W-1:0] y_full;
    logic              off_bottom;
    logic              active;

    assign x_base = x_mod_tbl[i_x];
    assign y_base = y_mod_tbl[i_y];

    assign y_sum  = SUM_W'(y_base) + SUM_W'(i_row_index);
    assign y_red1 = (y_sum >= SUM_W'(SCREEN_HEIGHT)) ? y_sum - SUM_W'(SCREEN_HEIGHT) : y_sum;
    assign y_red2 = (y_red1 >= SUM_W'(SCREEN_HEIGHT)) ? y_red1 - SUM_W'(SCREEN_HEIGHT) : y_red1;

    assign y_full     = FULL_W'(i_y) + FULL_W'(i_row_index);
    assign off_bottom = !i_wrap && (y_full >= FULL_W'(SCREEN_HEIGHT));
    assign active     = i_is_draw && (i_row_index < RIW'(MAX_SPRITE_ROWS)) && !i_rows_stopped;

    assign o_ctl.draw      = active && !off_bottom;
    assign o_ctl.stop_rows = active && off_bottom;
    assign o_row_addr      = i_is_draw ? y_red2[AW-1:0] : y_base;
    assign o_col           = x_base;

    always_comb begin
        logic [FULL_W-1:0] x_full;
        logic [XW:0]       x_sum;
        logic [XW:0]       x_red;
        o_mask = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            x_full = FULL_W'(i_x) + FULL_W'(b);
            x_sum  = (XW + 1)'(x_base) + (XW + 1)'(b);
            x_red  = (x_sum >= (XW + 1)'(SCREEN_WIDTH)) ? x_sum - (XW + 1)'(SCREEN_WIDTH) : x_sum;
            if (i_pattern[BYTE_W-1-b] && (i_wrap || (x_full < FULL_W'(SCREEN_WIDTH)))) begin
                o_mask[x_red[XW-1:0]] = 1'b1;
            end
        end
    end

endmodule

>>> hdl/monochrome_sprite_xor_framebuffer_top.sv
// ----------------------------------------------------------------------------
// monochrome_sprite_xor_framebuffer_top
// One-bit-per-pixel frame store taking clear, sprite-row draw and pixel read
// words, with XOR drawing and collision reporting.
// ----------------------------------------------------------------------------
// Command words arrive on the s_axis channel: tuser carries the kind (clear,
// draw row, read pixel), tdata the coordinates and row pattern, and tlast
// marks the final row of a sprite. Every accepted word yields exactly one
// result word on the m_axis channel, whose tlast is the sprite-done flag.
// A word is accepted in the idle state, which issues the frame row read;
// in the execute state the row is modified and written back and the result
// is loaded into the output register. The block takes no new word until
// the row read-modify-write of the current one has finished.
// A clear darkens the whole frame at once through per-row valid bits.
// If the receiver stalls, the result waits in the output register while the
// next word is still accepted; that word then holds in the execute state
// until the output register is free. After reset the frame is dark, no
// sprite is in progress and wrapping is enabled; no clearing pass is needed.
// The wrap register is written through the configuration write enable.
// ----------------------------------------------------------------------------
module monochrome_sprite_xor_framebuffer_top
    import msxf_pkg::*;
#(
    parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = SCREEN_HEIGHT_DEF,
    parameter int MAX_SPRITE_ROWS = MAX_SPRITE_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // x_coord [7:0], y_coord [15:8], sprite_bits [23:16]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]   i_s_axis_tuser,
    input  logic                i_s_axis_tlast,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // collision [0], pixel_value [1], zeros [7:2]
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast
);

    localparam int XW  = $clog2(SCREEN_WIDTH);
    localparam int AW  = $clog2(SCREEN_HEIGHT);
    localparam int RIW = $clog2(MAX_SPRITE_ROWS + 1);

    t_state r_state;
    t_state n_state;

    logic           r_wrap;
    logic [RIW-1:0] r_row_index;
    logic [RIW-1:0] n_row_index;
    logic           r_coll_seen;
    logic           n_coll_seen;
    logic           r_rows_stopped;
    logic           n_rows_stopped;

    t_kind             r_kind;
    logic              r_last;
    logic [AW-1:0]     r_addr;
    logic [XW-1:0]     r_col;
    logic [SCREEN_WIDTH-1:0] r_mask;
    t_row_ctl          r_ctl;

    logic r_m_valid;
    logic r_m_coll;
    logic r_m_pixel;
    logic r_m_last;
    logic n_m_coll;
    logic n_m_pixel;
    logic n_m_last;

    logic                    s_accept;
    logic                    fire;
    logic                    is_draw;
    logic [AW-1:0]           map_addr;
    logic [XW-1:0]           map_col;
    logic [SCREEN_WIDTH-1:0] map_mask;
    t_row_ctl                map_ctl;
    logic [SCREEN_WIDTH-1:0] rd_data;
    logic                    mem_clear;
    logic                    mem_wr_en;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign fire            = (r_state == ST_EXEC) && (!r_m_valid || i_m_axis_tready);
    assign is_draw         = (t_kind'(i_s_axis_tuser) == KIND_DRAW);

    msxf_pixel_map #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .MAX_SPRITE_ROWS(MAX_SPRITE_ROWS)
    ) u_pixel_map (
        .i_is_draw     (is_draw),
        .i_wrap        (r_wrap),
        .i_x           (i_s_axis_tdata[COORD_W-1:0]),
        .i_y           (i_s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_pattern     (i_s_axis_tdata[S_DATA_W-1:2*COORD_W]),
        .i_row_index   (r_row_index),
        .i_rows_stopped(r_rows_stopped),
        .o_row_addr    (map_addr),
        .o_col         (map_col),
        .o_mask        (map_mask),
        .o_ctl         (map_ctl)
    );

    msxf_frame_mem #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_frame_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (mem_clear),
        .i_rd_en  (s_accept),
        .i_rd_addr(map_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(r_addr),
        .i_wr_data(rd_data ^ r_mask)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        logic hit;
        hit            = r_ctl.draw && (|(rd_data & r_mask));
        n_row_index    = r_row_index;
        n_coll_seen    = r_coll_seen;
        n_rows_stopped = r_rows_stopped;
        n_m_coll       = 1'b0;
        n_m_pixel      = 1'b0;
        n_m_last       = 1'b0;
        mem_clear      = 1'b0;
        mem_wr_en      = 1'b0;
        if (fire) begin
            unique case (r_kind)
                KIND_CLEAR: begin
                    mem_clear      = 1'b1;
                    n_row_index    = '0;
                    n_coll_seen    = 1'b0;
                    n_rows_stopped = 1'b0;
                    n_m_last       = 1'b1;
                end
                KIND_DRAW: begin
                    mem_wr_en = r_ctl.draw;
                    n_m_coll  = r_coll_seen || hit;
                    n_m_last  = r_last;
                    if (r_last) begin
                        n_row_index    = '0;
                        n_coll_seen    = 1'b0;
                        n_rows_stopped = 1'b0;
                    end else begin
                        n_coll_seen    = r_coll_seen || hit;
                        n_rows_stopped = r_rows_stopped || r_ctl.stop_rows;
                        if (r_row_index < RIW'(MAX_SPRITE_ROWS)) begin
                            n_row_index = r_row_index + RIW'(1);
                        end
                    end
                end
                KIND_READ: begin
                    n_m_pixel = rd_data[r_col];
                    n_m_last  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_wrap         <= 1'b1;
            r_row_index    <= '0;
            r_coll_seen    <= 1'b0;
            r_rows_stopped <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_row_index    <= n_row_index;
            r_coll_seen    <= n_coll_seen;
            r_rows_stopped <= n_rows_stopped;
            if (i_cfg_wr_en) begin
                r_wrap <= i_cfg_wr_data;
            end
            if (fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind <= t_kind'(i_s_axis_tuser);
            r_last <= i_s_axis_tlast;
            r_addr <= map_addr;
            r_col  <= map_col;
            r_mask <= map_mask;
            r_ctl  <= map_ctl;
        end
        if (fire) begin
            r_m_coll  <= n_m_coll;
            r_m_pixel <= n_m_pixel;
            r_m_last  <= n_m_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {(M_DATA_W - 2)'(0), r_m_pixel, r_m_coll};
    assign o_m_axis_tlast  = r_m_last;

endmodule

>>> bench/tb_monochrome_sprite_xor_framebuffer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_monochrome_sprite_xor_framebuffer_top
// Self-checking bench for the sprite XOR frame store. A scoreboard keeps its
// own copy of the one-bit frame, the sprite row count, the collision flag and
// the wrap setting. It works out the result word of every accepted command
// word and compares it with the words that leave the block, oldest first.
// A short directed run covers clipping, wrapping, collisions, clears inside a
// sprite, reads mid-sprite and the unused kind. Random sprites, reads and
// noise follow under both wrap settings and three patterns of idling.
// ----------------------------------------------------------------------------
import msxf_pkg::*;

typedef struct {
    bit collision;
    bit pixel_value;
    bit sprite_done;
} t_frame_result;

class frame_scoreboard;
    bit [SCREEN_WIDTH_DEF-1:0] lit_rows [SCREEN_HEIGHT_DEF];
    int unsigned               rows_drawn;
    bit                        hit_seen;
    bit                        rows_halted;
    bit                        wrap_on;
    t_frame_result             expected_results [$];
    int                        failures;

    function new();
        foreach (lit_rows[r]) lit_rows[r] = '0;
        rows_drawn  = 0;
        hit_seen    = 1'b0;
        rows_halted = 1'b0;
        wrap_on     = 1'b1;
        failures    = 0;
    endfunction

    function void set_wrap(bit value);
        wrap_on = value;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [7:0] x, logic [7:0] y,
                               logic [7:0] pattern, logic last);
        t_frame_result res;
        int            row;
        int            col;
        int            b;
        res = '{1'b0, 1'b0, 1'b0};
        if (kind == KIND_CLEAR) begin
            foreach (lit_rows[r]) lit_rows[r] = '0;
            rows_drawn  = 0;
            hit_seen    = 1'b0;
            rows_halted = 1'b0;
            res.sprite_done = 1'b1;
        end else if (kind == KIND_DRAW) begin
            if (rows_drawn < MAX_SPRITE_ROWS_DEF && !rows_halted) begin
                row = int'(y) + int'(rows_drawn);
                if (!wrap_on && row >= SCREEN_HEIGHT_DEF) begin
                    rows_halted = 1'b1;
                end else begin
                    for (b = 0; b < 8; b++) begin
                        col = int'(x) + b;
                        if ((wrap_on || col < SCREEN_WIDTH_DEF) && pattern[7-b]) begin
                            col = col % SCREEN_WIDTH_DEF;
                            if (lit_rows[row % SCREEN_HEIGHT_DEF][col])
                                hit_seen = 1'b1;
                            lit_rows[row % SCREEN_HEIGHT_DEF][col] ^= 1'b1;
                        end
                    end
                end
            end
            if (rows_drawn < MAX_SPRITE_ROWS_DEF)
                rows_drawn++;
            res.collision = hit_seen;
            if (last) begin
                res.sprite_done = 1'b1;
                rows_drawn  = 0;
                hit_seen    = 1'b0;
                rows_halted = 1'b0;
            end
        end else if (kind == KIND_READ) begin
            res.pixel_value = lit_rows[y % SCREEN_HEIGHT_DEF][x % SCREEN_WIDTH_DEF];
            res.sprite_done = 1'b1;
        end
        expected_results.push_back(res);
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data, logic done);
        t_frame_result exp_res;
        if (expected_results.size() == 0) begin
            $error("result word arrived with no command outstanding");
            failures++;
            return;
        end
        exp_res = expected_results.pop_front();
        if (data[0] !== exp_res.collision) begin
            $error("collision: expected %0d, got %0d", exp_res.collision, data[0]);
            failures++;
        end
        if (data[1] !== exp_res.pixel_value) begin
            $error("pixel_value: expected %0d, got %0d", exp_res.pixel_value, data[1]);
            failures++;
        end
        if (done !== exp_res.sprite_done) begin
            $error("sprite_done: expected %0d, got %0d", exp_res.sprite_done, done);
            failures++;
        end
        if (data[M_DATA_W-1:2] !== '0) begin
            $error("padding: expected 0, got %0h", data[M_DATA_W-1:2]);
            failures++;
        end
    endfunction
endclass

module tb_monochrome_sprite_xor_framebuffer_top;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_wr_en      = 1'b0;
    logic                i_cfg_wr_data    = 1'b0;
    logic                i_s_axis_tvalid  = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata   = '0;
    logic [KIND_W-1:0]   i_s_axis_tuser   = '0;
    logic                i_s_axis_tlast   = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic                o_m_axis_tlast;

    frame_scoreboard sb = new();
    int              sender_idle_pct   = 10;
    int              receiver_idle_pct = 76;
    int              words_sent        = 0;
    logic [7:0]      last_x            = '0;
    logic [7:0]      last_y            = '0;

    monochrome_sprite_xor_framebuffer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit roll_idle(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] pick_x();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 67));
    endfunction

    function automatic logic [7:0] pick_y();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 34));
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [7:0] x,
                             input logic [7:0] y, input logic [7:0] pattern,
                             input logic last);
        @(negedge i_clk);
        while (roll_idle(sender_idle_pct)) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {pattern, y, x};
        i_s_axis_tuser  = kind;
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_command(kind, x, y, pattern, last);
        if (kind != KIND_UNUSED)
            words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_wrap(input bit value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.set_wrap(value);
    endtask

    task automatic run_phase(input int count);
        int         target;
        int         rows;
        int         r;
        int         k;
        logic [7:0] x0;
        logic [7:0] y0;
        bit         paused;
        target = words_sent + count;
        paused = 1'b0;
        while (words_sent < target) begin
            if (!paused && words_sent >= target - count / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                rows = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 18)
                                                    : $urandom_range(1, 6);
                x0 = pick_x();
                y0 = pick_y();
                for (k = 0; k < rows; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(KIND_READ, 8'(x0 + $urandom_range(0, 9)), 8'(y0 + k),
                                  rand_byte(), rand_bit());
                    send_word(KIND_DRAW, x0, y0, rand_byte(), k == rows - 1);
                end
                last_x = x0;
                last_y = y0;
            end else if (r < 78) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(KIND_READ, rand_byte(), rand_byte(), rand_byte(), rand_bit());
                else
                    send_word(KIND_READ, 8'(last_x + $urandom_range(0, 8)),
                              8'(last_y + $urandom_range(0, 5)), rand_byte(), rand_bit());
            end else if (r < 84) begin
                rows = $urandom_range(1, 4);
                for (k = 0; k < rows; k++)
                    send_word(KIND_DRAW, pick_x(), pick_y(), rand_byte(), rand_bit());
            end else if (r < 87) begin
                send_word(KIND_CLEAR, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            end else if (r < 91) begin
                send_word(KIND_UNUSED, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            end else begin
                send_word(KIND_DRAW, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = !roll_idle(receiver_idle_pct);
            @(posedge i_clk);
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_wrap(1'b1);
        send_word(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);
        send_word(KIND_DRAW,  8'd60, 8'd30, 8'hFF, 1'b0);
        send_word(KIND_DRAW,  8'd60, 8'd30, 8'h81, 1'b1);
        send_word(KIND_DRAW,  8'd0,  8'd0,  8'hFF, 1'b1);
        send_word(KIND_DRAW,  8'd0,  8'd0,  8'hFF, 1'b1);
        send_word(KIND_READ,  8'hFF, 8'hFF, 8'h00, 1'b0);
        send_word(KIND_READ,  8'd67, 8'd32, 8'hFF, 1'b1);
        send_word(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_word(KIND_DRAW,  8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(KIND_READ,  8'd63, 8'd31, 8'h00, 1'b0);
        send_word(KIND_DRAW,  8'hFF, 8'hFF, 8'h00, 1'b1);

        write_wrap(1'b0);
        send_word(KIND_DRAW,  8'd60, 8'd31, 8'hFF, 1'b0);
        send_word(KIND_DRAW,  8'd60, 8'd31, 8'hFF, 1'b1);
        send_word(KIND_DRAW,  8'd64, 8'd0,  8'hFF, 1'b1);
        send_word(KIND_DRAW,  8'd0,  8'd32, 8'hFF, 1'b1);
        send_word(KIND_DRAW,  8'd0,  8'd30, 8'hFF, 1'b0);
        send_word(KIND_DRAW,  8'd0,  8'd30, 8'h55, 1'b0);
        send_word(KIND_DRAW,  8'd0,  8'd30, 8'hFF, 1'b0);
        send_word(KIND_READ,  8'd1,  8'd30, 8'h00, 1'b0);
        send_word(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1);
        send_word(KIND_DRAW,  8'd0,  8'd0,  8'hFF, 1'b1);

        sender_idle_pct   = 10;
        receiver_idle_pct = 76;
        write_wrap(1'b0);
        run_phase(75);
        write_wrap(1'b1);
        run_phase(75);

        sender_idle_pct   = 76;
        receiver_idle_pct = 10;
        write_wrap(1'b1);
        run_phase(75);
        write_wrap(1'b0);
        run_phase(75);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_wrap(1'b0);
        run_phase(75);
        write_wrap(1'b1);
        run_phase(75);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
